### rtl/spq_pkg.sv
// Package for the sorted priority queue: beat types, codes and the ordering function.
package spq_pkg;

    localparam int PRIO_W    = 4;
    localparam int NAME_W    = 48;
    localparam int PAYLOAD_W = 32;
    localparam int OCC_W     = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                 op;
        logic [PRIO_W-1:0]    priority_req;
        logic [NAME_W-1:0]    name_key;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [PRIO_W-1:0]    head_priority;
        logic [NAME_W-1:0]    head_name;
        logic [PAYLOAD_W-1:0] head_payload;
        logic [OCC_W-1:0]     occupancy;
    } result_t;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [NAME_W-1:0]    name;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

    // True when entry a must be served strictly before entry b.
    function automatic logic goes_before(entry_t a, entry_t b);
        return (a.prio > b.prio) || ((a.prio == b.prio) && (a.name < b.name));
    endfunction

endpackage

### rtl/spq_cell.sv
// One slot of the sorted queue chain with its own ordering compare.
module spq_cell
    import spq_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
)
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    input  logic      left_keep,
    input  logic      valid,
    output entry_t    entry,
    output logic      keep
);

    entry_t slot_reg;
    entry_t slot_next;

    // The head stays put unless the new entry beats it; any later slot stays
    // put only while it beats the new entry.
    always_comb
    begin
        if (IS_HEAD)
        begin
            keep = valid && !goes_before(new_entry, slot_reg);
        end
        else
        begin
            keep = valid && goes_before(slot_reg, new_entry);
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.push)
        begin
            if (!keep)
            begin
                slot_next = left_keep ? new_entry : left_entry;
            end
        end
        else if (ctl.pop)
        begin
            slot_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign entry = slot_reg;

endmodule

### rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain, fill count and result register.
//
// The queue holds up to QUEUE_DEPTH entries in service order in a chain of
// cells, slot 0 being the head. A command beat is taken at any rising edge
// where start is high; busy never rises, so one push or pop is taken every
// clock cycle. Each cell compares its entry against the new key in parallel
// and, in the same cycle, holds, loads the new entry or takes its neighbor's,
// so the time a command takes does not depend on occupancy. The result
// beat appears on result in the cycle after the command and is marked by done
// for exactly that cycle; it must be captured then, since the block cannot be
// held off. A push into a full queue returns status full and a pop from an
// empty queue returns status empty, both leaving the queue unchanged. Head
// fields are zero except on a successful pop. Names are compared over their
// low NAME_CHARS bytes only; higher bits are dropped on entry.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_CHARS  = 6
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int NAME_BITS = (NAME_CHARS * 8 > NAME_W) ? NAME_W : NAME_CHARS * 8;
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - NAME_BITS);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    cell_ctl_t ctl;
    entry_t    new_entry;
    entry_t    slot_q [QUEUE_DEPTH];
    logic      keep   [QUEUE_DEPTH];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (fill_reg == FILL_FULL);
    assign is_empty = (fill_reg == '0);

    assign new_entry.prio    = cmd.priority_req;
    assign new_entry.name    = cmd.name_key & NAME_MASK;
    assign new_entry.payload = cmd.payload;

    // Refused commands leave the chain untouched.
    assign ctl.push = accept && (cmd.op == OP_PUSH) && !is_full;
    assign ctl.pop  = accept && (cmd.op == OP_POP) && !is_empty;

    // Slot j loads from j-1 when the new entry lands ahead of it, and from
    // j+1 on a pop. The head loads the new entry when it does not keep.
    genvar j;
    generate
        for (j = 0; j < QUEUE_DEPTH; j++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;

            if (j == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_k = 1'b1;
            end
            else
            begin : g_body
                assign left_e = slot_q[j-1];
                assign left_k = keep[j-1];
            end

            if (j == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = slot_q[j];
            end
            else
            begin : g_inner
                assign right_e = slot_q[j+1];
            end

            spq_cell #(
                .IS_HEAD (j == 0)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .right_entry (right_e),
                .left_keep   (left_k),
                .valid       (FILL_W'(j) < fill_reg),
                .entry       (slot_q[j]),
                .keep        (keep[j])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.push)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_comb
    begin
        result_next               = '0;
        result_next.status        = ST_OK;
        if (cmd.op == OP_PUSH)
        begin
            if (is_full)
            begin
                result_next.status = ST_FULL;
            end
        end
        else if (is_empty)
        begin
            result_next.status = ST_EMPTY;
        end
        else
        begin
            result_next.head_priority = slot_q[0].prio;
            result_next.head_name     = slot_q[0].name;
            result_next.head_payload  = slot_q[0].payload;
        end
        result_next.occupancy = OCC_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted command gives exactly one result beat in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("result beat does not follow its command");

    // The fill count never passes the depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond queue depth");

    // A full refusal reports a full queue.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> result.occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("full refusal with wrong occupancy");

    // Refused commands return zero head fields and an unchanged count.
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
        (result.head_priority == '0 && result.head_name == '0 &&
         result.head_payload == '0 && $stable(fill_reg)))
        else $error("refused command changed state or returned data");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sorted priority queue: directed and random push/pop traffic.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int NAME_CHARS     = 6;
    localparam int RANDOM_ITEMS   = 560;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_LIMIT    = 50;
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_CHARS);

    logic    clk;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    sorted_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NAME_CHARS (NAME_CHARS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Shadow copy of the queue contents, kept in service order with the head at index 0.
    entry_t    shadow_slots [QUEUE_DEPTH];
    int        shadow_fill = 0;
    result_t   awaited_results [$];

    int errors         = 0;
    int beats_checked  = 0;
    int stored_count   = 0;
    int popped_count   = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;
    int peak_fill      = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    int burst_left  = 0;
    bit steady_send = 1'b0;

    // True when entry a is served strictly ahead of entry b.
    function automatic bit ranks_ahead(entry_t a, entry_t b);
        if (a.prio != b.prio)
        begin
            return a.prio > b.prio;
        end
        return a.name < b.name;
    endfunction

    // Applies one accepted command to the shadow queue and returns the result beat it gives.
    function automatic result_t predict_queue_op(cmd_t c);
        result_t r;
        entry_t  e;
        int      pos;
        r         = '0;
        e.prio    = c.priority_req;
        e.name    = c.name_key & NAME_MASK;
        e.payload = c.payload;
        if (c.op == OP_PUSH)
        begin
            if (shadow_fill >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // A key identical to the head lands right behind it; elsewhere a
                // new entry goes ahead of older entries with the same key.
                if (shadow_fill == 0 || ranks_ahead(e, shadow_slots[0]))
                begin
                    pos = 0;
                end
                else
                begin
                    pos = 1;
                    while (pos < shadow_fill && ranks_ahead(shadow_slots[pos], e))
                    begin
                        pos++;
                    end
                end
                for (int i = shadow_fill; i > pos; i--)
                begin
                    shadow_slots[i] = shadow_slots[i - 1];
                end
                shadow_slots[pos] = e;
                shadow_fill++;
            end
        end
        else
        begin
            if (shadow_fill == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.head_priority = shadow_slots[0].prio;
                r.head_name     = shadow_slots[0].name;
                r.head_payload  = shadow_slots[0].payload;
                for (int i = 1; i < shadow_fill; i++)
                begin
                    shadow_slots[i - 1] = shadow_slots[i];
                end
                shadow_fill--;
            end
        end
        r.occupancy = OCC_W'(shadow_fill);
        return r;
    endfunction

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    task automatic check_result(result_t want, result_t got);
        if (got.status !== want.status)
        begin
            report_field("status", 64'(want.status), 64'(got.status));
        end
        if (got.head_priority !== want.head_priority)
        begin
            report_field("head_priority", 64'(want.head_priority), 64'(got.head_priority));
        end
        if (got.head_name !== want.head_name)
        begin
            report_field("head_name", 64'(want.head_name), 64'(got.head_name));
        end
        if (got.head_payload !== want.head_payload)
        begin
            report_field("head_payload", 64'(want.head_payload), 64'(got.head_payload));
        end
        if (got.occupancy !== want.occupancy)
        begin
            report_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
        end
    endtask

    // Both handshakes are sampled at the rising edge, before the block's own
    // updates land. A result beat always belongs to an earlier command, so the
    // check runs before a command taken at the same edge is predicted.
    always @(posedge clk)
    begin : beat_monitor
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result beat with nothing expected, got %0h",
                             $time, result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_result(want, result);
                    beats_checked++;
                end
            end
            if (start && !busy)
            begin
                want = predict_queue_op(cmd);
                awaited_results.push_back(want);
                if (want.status == ST_FULL)
                begin
                    full_refusals++;
                end
                else if (want.status == ST_EMPTY)
                begin
                    empty_refusals++;
                end
                else if (cmd.op == OP_PUSH)
                begin
                    stored_count++;
                end
                else
                begin
                    popped_count++;
                end
                if (shadow_fill > peak_fill)
                begin
                    peak_fill = shadow_fill;
                end
            end
        end
    end

    // Ends the run if no command and no result moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sends one command beat; returns at the edge where it was taken.
    task automatic send_beat(cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_send ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    function automatic cmd_t push_cmd(logic [PRIO_W-1:0] prio, logic [NAME_W-1:0] name,
                                      logic [PAYLOAD_W-1:0] payload);
        cmd_t c;
        c.op           = OP_PUSH;
        c.priority_req = prio;
        c.name_key     = name;
        c.payload      = payload;
        return c;
    endfunction

    // Pops carry random key fields, which the block must ignore.
    function automatic cmd_t pop_cmd();
        cmd_t c;
        c.op           = OP_POP;
        c.priority_req = PRIO_W'($urandom);
        c.name_key     = {16'($urandom), 32'($urandom)};
        c.payload      = $urandom;
        return c;
    endfunction

    // Half of the names are drawn from a short list so that equal keys turn up often.
    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] name;
        int                len;
        name = '0;
        case ($urandom_range(0, 3))
            0:
            begin
                name = {16'($urandom), 32'($urandom)};
            end
            1:
            begin
                len = $urandom_range(1, NAME_CHARS);
                for (int k = 0; k < NAME_CHARS; k++)
                begin
                    name = {name[NAME_W-9:0], (k < len) ? 8'($urandom_range(65, 90)) : 8'h00};
                end
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: name = 48'h414C50484100;
                    1: name = 48'h425241564F00;
                    default: name = 48'h44454C544100;
                endcase
            end
        endcase
        return name;
    endfunction

    function automatic logic [PRIO_W-1:0] random_priority();
        case ($urandom_range(0, 3))
            0: return PRIO_W'($urandom);
            1: return $urandom_range(0, 1) ? 4'd15 : 4'd0;
            default: return PRIO_W'($urandom_range(6, 8));
        endcase
    endfunction

    function automatic cmd_t random_push();
        return push_cmd(random_priority(), random_name(), $urandom);
    endfunction

    task automatic test_empty_pop();
        send_beat(pop_cmd());
        send_beat(pop_cmd());
    endtask

    // Extreme priorities, names and payloads; names around the top bit check
    // that the key is ordered as an unsigned number.
    task automatic test_extreme_fields();
        send_beat(push_cmd(4'd0, 48'hFFFF_FFFF_FFFF, 32'h0000_0000));
        send_beat(push_cmd(4'd15, 48'h0000_0000_0000, 32'hFFFF_FFFF));
        send_beat(push_cmd(4'd4, 48'h8000_0000_0000, 32'hA5A5_A5A5));
        send_beat(push_cmd(4'd4, 48'h7FFF_FFFF_FFFF, 32'h5A5A_5A5A));
        send_beat(push_cmd(4'd15, 48'h0000_0000_0001, 32'h0000_0001));
        repeat (5) send_beat(pop_cmd());
    endtask

    // Equal keys, told apart by payload: first behind a matching head, then
    // with a different head in front, where the newest goes ahead of its twins.
    task automatic test_identical_keys();
        send_beat(push_cmd(4'd7, 48'h4B4559000000, 32'd1));
        send_beat(push_cmd(4'd7, 48'h4B4559000000, 32'd2));
        send_beat(push_cmd(4'd7, 48'h4B4559000000, 32'd3));
        send_beat(push_cmd(4'd9, 48'h4D0000000000, 32'd5));
        send_beat(push_cmd(4'd7, 48'h4B4559000000, 32'd4));
        repeat (5) send_beat(pop_cmd());
    endtask

    // Fills the queue past its depth, then drains it past empty.
    task automatic test_full_boundary();
        steady_send = 1'b1;
        repeat (QUEUE_DEPTH + 2) send_beat(random_push());
        steady_send = 1'b0;
        repeat (QUEUE_DEPTH + 2) send_beat(pop_cmd());
    endtask

    // Episodes lean toward pushes, toward pops or neither, so the queue
    // swings between full and empty with plenty of ties along the way.
    task automatic test_random_traffic(int count);
        int sent;
        int push_pct;
        int episode;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 2))
                0: push_pct = 90;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            steady_send = ($urandom_range(0, 3) == 0);
            episode     = $urandom_range(8, 40);
            repeat (episode)
            begin
                if ($urandom_range(0, 99) < push_pct)
                begin
                    send_beat(random_push());
                end
                else
                begin
                    send_beat(pop_cmd());
                end
                sent++;
            end
        end
        steady_send = 1'b0;
    endtask

    initial
    begin : stimulus
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pop();
        test_extreme_fields();
        test_identical_keys();
        test_full_boundary();
        test_random_traffic(RANDOM_ITEMS);
        start <= 1'b0;

        waited = 0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_results.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d result beats never arrived", $time, awaited_results.size());
        end
        repeat (4) @(posedge clk);

        $display("Ran %0d commands: %0d stored, %0d popped, %0d refused full, %0d refused empty.",
                 stored_count + popped_count + full_refusals + empty_refusals,
                 stored_count, popped_count, full_refusals, empty_refusals);
        $display("Checked %0d result beats; peak occupancy %0d of %0d.",
                 beats_checked, peak_fill, QUEUE_DEPTH);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
